>>> sv/assert_macros.svh
// Assertion macros shared by the spline evaluator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> sv/crse_pkg.sv
// Package: constants, codes and helpers for the Catmull-Rom spline evaluator.
package crse_pkg;

  localparam int unsigned MAX_POINTS = 1024;
  localparam int unsigned PT_W       = 16;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned ADDR_W     = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W      = ADDR_W + 1;
  localparam int unsigned VAL_W      = 20;

  typedef enum logic [2:0] {
    OP_EVAL   = 3'd0,
    OP_APPEND = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_WRITE  = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FEW   = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_RBACK,
    S_SEG,
    S_FETCH,
    S_COEF,
    S_U1,
    S_U2,
    S_U2B,
    S_U3,
    S_FIN,
    S_DONE
  } state_e;

  // Round half up, then floor divide by 2^k.
  function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                     input int unsigned k);
    logic signed [63:0] r;
    r = (v + (64'sd1 <<< (k - 1))) >>> k;
    return r;
  endfunction

endpackage

>>> sv/crse_ram.sv
// Point table memory: one write port, one registered read port.
module crse_ram (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [crse_pkg::ADDR_W-1:0] waddr_i,
  input  logic [crse_pkg::PT_W-1:0]   wdata_i,
  input  logic [crse_pkg::ADDR_W-1:0] raddr_i,
  output logic [crse_pkg::PT_W-1:0]   rdata_o
);
  import crse_pkg::*;

  logic [PT_W-1:0] mem [MAX_POINTS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> sv/catmull_rom_spline_eval.sv
// Top level: uniform Catmull-Rom spline evaluator over a table of control points.
// One item at a time. Append, clear and write pass through EXEC and DONE; a read
// in range adds RBACK; evaluate with four or more points adds SEG, FETCH (four serial
// reads of the single memory port), COEF and a chain of registered multiply
// steps. The next transfer is taken once the result is loaded, back in IDLE; a
// result still waiting on m_tready_i holds the next one back until it is taken.
// Reset clears the point count and control state; the table holds no reset value
// and needs no clearing pass.
module catmull_rom_spline_eval (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [47:0] s_tdata_i,  // position[19:0], point_value[35:20], point_index[45:36]
  input  logic [2:0]  s_tuser_i,  // opcode[2:0]
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [23:0] m_tdata_o   // value[19:0], status[21:20]
);
  import crse_pkg::*;
  `include "assert_macros.svh"

  state_e state_q, state_d;

  logic [2:0]               op_q;
  logic signed [19:0]       pos_q;
  logic [PT_W-1:0]          pv_q;
  logic [ADDR_W-1:0]        idx_q;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic signed [31:0]       xs_q;
  logic [ADDR_W-1:0]        base_q, base_d;
  logic signed [17:0]       t_q, t_d;
  logic [1:0]               k_q;
  logic signed [PT_W-1:0]   p_q [4];
  logic signed [19:0]       a_q, b_q, c_q;
  logic signed [39:0]       u_q;
  logic signed [63:0]       prod_q;
  logic signed [19:0]       res_val_q, res_val_d;
  logic [1:0]               res_st_q, res_st_d;
  logic                     m_valid_q;
  logic [23:0]              m_data_q;

  logic                     we;
  logic [ADDR_W-1:0]        waddr, raddr;
  logic [PT_W-1:0]          wdata, rdata;

  logic                     accept, out_free;
  logic [ADDR_W-1:0]        cm3;
  logic signed [31:0]       xs_d, mag;
  logic signed [16:0]       ip;
  logic signed [17:0]       tr;
  logic signed [12:0]       last;
  logic signed [63:0]       u3, fin;

  assign accept   = s_tvalid_i && s_tready_o;
  assign out_free = !m_valid_q || m_tready_i;
  assign s_tready_o = (state_q == S_IDLE);
  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

  crse_ram u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Segment index and fraction, truncated toward zero, then clamped.
  always_comb begin
    mag  = xs_q[31] ? -xs_q : xs_q;
    ip   = xs_q[31] ? -$signed({1'b0, mag[31:16]}) : $signed({1'b0, mag[31:16]});
    tr   = xs_q[31] ? -$signed({2'b00, mag[15:0]}) : $signed({2'b00, mag[15:0]});
    last = $signed({2'b00, cnt_q}) - 13'sd4;
    base_d = '0;
    t_d    = tr;
    if (ip < 0) begin
      t_d = '0;
    end else if (ip > 17'(last)) begin
      base_d = last[ADDR_W-1:0];
      t_d    = 18'sd1 <<< FRAC_BITS;
    end else begin
      base_d = ip[ADDR_W-1:0];
    end
  end

  always_comb begin
    cm3  = ADDR_W'(cnt_q - CNT_W'(3));
    xs_d = 32'(pos_q) * $signed({21'd0, cm3});
    u3   = round_shift(prod_q, FRAC_BITS);
    fin  = round_shift(u3, FRAC_BITS + 1) + 64'(p_q[1]);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_EXEC;
      S_EXEC: begin
        state_d = S_DONE;
        if (op_q == OP_EVAL && cnt_q >= CNT_W'(4)) state_d = S_SEG;
        if (op_q == OP_READ && CNT_W'(idx_q) < cnt_q) state_d = S_RBACK;
      end
      S_RBACK: state_d = S_DONE;
      S_SEG:   state_d = S_FETCH;
      S_FETCH: if (k_q == 2'd3) state_d = S_COEF;
      S_COEF:  state_d = S_U1;
      S_U1:    state_d = S_U2;
      S_U2:    state_d = S_U2B;
      S_U2B:   state_d = S_U3;
      S_U3:    state_d = S_FIN;
      S_FIN:   state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs: memory control, count update, result
  always_comb begin
    we        = 1'b0;
    waddr     = idx_q;
    wdata     = pv_q;
    raddr     = base_q + ADDR_W'(k_q) + ADDR_W'(1);
    cnt_d     = cnt_q;
    res_val_d = res_val_q;
    res_st_d  = res_st_q;
    case (state_q)
      S_EXEC: begin
        raddr     = idx_q;
        res_val_d = '0;
        res_st_d  = ST_OK;
        case (op_q)
          OP_EVAL: if (cnt_q < CNT_W'(4)) res_st_d = ST_FEW;
          OP_APPEND: begin
            if (cnt_q == CNT_W'(MAX_POINTS)) begin
              res_st_d = ST_FULL;
            end else begin
              we    = 1'b1;
              waddr = cnt_q[ADDR_W-1:0];
              cnt_d = cnt_q + CNT_W'(1);
            end
          end
          OP_CLEAR: cnt_d = '0;
          OP_WRITE: begin
            if (CNT_W'(idx_q) >= cnt_q) res_st_d = ST_RANGE;
            else we = 1'b1;
          end
          OP_READ: if (CNT_W'(idx_q) >= cnt_q) res_st_d = ST_RANGE;
          default: ;
        endcase
      end
      S_RBACK: res_val_d = 20'($signed(rdata));
      S_SEG:   raddr = base_d;
      S_FIN: begin
        if (fin > 64'sd524287)       res_val_d = 20'sd524287;
        else if (fin < -64'sd524288) res_val_d = -20'sd524288;
        else                         res_val_d = fin[19:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
      k_q       <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == S_SEG) k_q <= '0;
      else if (state_q == S_FETCH) k_q <= k_q + 2'd1;
      if (state_q == S_DONE && out_free) m_valid_q <= 1'b1;
      else if (m_tready_i) m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= s_tuser_i;
      pos_q <= $signed(s_tdata_i[19:0]);
      pv_q  <= s_tdata_i[35:20];
      idx_q <= s_tdata_i[45:36];
    end
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
    case (state_q)
      S_EXEC:  xs_q <= xs_d;
      S_SEG: begin
        base_q <= base_d;
        t_q    <= t_d;
      end
      S_FETCH: p_q[k_q] <= $signed(rdata);
      S_COEF: begin
        a_q <= -20'(p_q[0]) + 20'sd3 * 20'(p_q[1]) - 20'sd3 * 20'(p_q[2]) + 20'(p_q[3]);
        b_q <= 20'sd2 * 20'(p_q[0]) - 20'sd5 * 20'(p_q[1]) + 20'sd4 * 20'(p_q[2])
               - 20'(p_q[3]);
        c_q <= 20'(p_q[2]) - 20'(p_q[0]);
      end
      S_U1:  u_q <= 40'(a_q) * 40'(t_q) + (40'(b_q) <<< FRAC_BITS);
      S_U2:  prod_q <= 64'(u_q) * 64'(t_q);
      S_U2B: u_q <= 40'(round_shift(prod_q, FRAC_BITS)) + (40'(c_q) <<< FRAC_BITS);
      S_U3:  prod_q <= 64'(u_q) * 64'(t_q);
      default: ;
    endcase
    if (state_q == S_DONE && out_free) begin
      m_data_q <= {2'b00, res_st_q, res_val_q};
    end
  end

  `ASSERT_ALWAYS(a_cnt_max, cnt_q <= CNT_W'(MAX_POINTS), "point count beyond table depth")
  `ASSERT_NEXT(a_one_item, accept, !s_tready_o, "second transfer taken while busy")
  `ASSERT_ALWAYS(a_few_zero, !(m_valid_q && m_data_q[21:20] == ST_FEW) || m_data_q[19:0] == '0,
    "nonzero value with too-few-points status")

endmodule
